### src/bmss_pkg.sv
// Shared types and constants for the binary mask similarity score core.
package bmss_pkg;

	localparam int MASK_W  = 64;
	localparam int CNT_W   = 7;
	localparam int SCORE_W = 17;
	localparam int Q_W     = 17;
	localparam int DU_W    = 11;
	localparam int DEN_W   = 21;
	localparam int RHS_W   = 53;
	localparam int P_W     = 58;
	localparam int QD_W    = 40;
	localparam int LHS_W   = 60;

	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 7;

	localparam logic [CFG_IDX_W-1:0] REG_SCORE_MODE   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_TISSUE_COUNT = 2'd1;

	localparam logic [SCORE_W-1:0] SCORE_HALF = 17'd32768;
	localparam logic [SCORE_W-1:0] SCORE_ZERO = 17'd0;

	typedef struct packed {
		logic [CNT_W-1:0] cnt_u;
		logic [CNT_W-1:0] cnt_v;
		logic [CNT_W-1:0] cnt_b;
	} bmss_cnt_t;

	// One item inside the bit-by-bit rounding search.
	// Mode 0 uses qd as q*m and den as m; mode 1 tracks q^2*den in p and q*den in qd.
	typedef struct packed {
		logic               mode;
		logic [Q_W-1:0]     q;
		logic [P_W-1:0]     p;
		logic [QD_W-1:0]    qd;
		logic [DEN_W-1:0]   den;
		logic [RHS_W-1:0]   rhs;
		logic               neg;
		logic               ovr;
		logic [SCORE_W-1:0] ovr_score;
		bmss_cnt_t          cnt;
	} bmss_srch_t;

endpackage

### src/binary_mask_similarity_score_core.sv
// Binary mask similarity score core: top level with config registers and search pipeline.
// Scores one edge per clock from two presence masks: popcounts of u, v and u AND v, then
// either the rounded coexistence ratio or the shifted correlation 0.5 + 0.5*phi in Q1.16.
// The pipeline has three popcount stages, two setup stages, seventeen stages of the
// bit-per-stage rounding search and the output register. One item enters every cycle while
// the output is taken; a stalled output holds the whole pipeline. Write score_mode and
// tissue_count only while no items are in flight.
module binary_mask_similarity_score_core #(
	parameter int MAX_TISSUES = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [63:0] mask_u,
	input  logic [63:0] mask_v,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [16:0] score,
	output logic [6:0]  count_u,
	output logic [6:0]  count_v,
	output logic [6:0]  count_both,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [6:0]  cfg_data
);
	import bmss_pkg::*;

	logic             mode_q;
	logic [6:0]       tcount_q;
	logic [6:0]       n_eff;
	logic             en;

	logic             pc_valid;
	bmss_cnt_t        pc_cnt;
	logic             pr_valid;
	bmss_srch_t       pr_srch;

	bmss_srch_t       stp_s [Q_W];
	logic             vld_s [Q_W];
	bmss_srch_t       nxt   [Q_W];

	logic             out_vld_q;
	logic [16:0]      score_q;
	bmss_cnt_t        cnt_q;
	bmss_srch_t       last;
	logic [16:0]      score_d;

	assign n_eff     = (tcount_q > 7'(MAX_TISSUES)) ? 7'(MAX_TISSUES) : tcount_q;
	assign en        = !(out_vld_q && out_stall);
	assign in_stall  = !en;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q   <= 1'b1;
			tcount_q <= 7'd64;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_SCORE_MODE:   mode_q   <= cfg_data[0];
				REG_TISSUE_COUNT: tcount_q <= cfg_data;
				default: ;
			endcase
		end
	end

	bmss_popcnt u_popcnt (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (in_valid),
		.mask_u    (mask_u),
		.mask_v    (mask_v),
		.n_eff     (n_eff),
		.out_valid (pc_valid),
		.cnt       (pc_cnt)
	);

	bmss_prep u_prep (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (pc_valid),
		.cnt       (pc_cnt),
		.n_eff     (n_eff),
		.mode      (mode_q),
		.out_valid (pr_valid),
		.srch      (pr_srch)
	);

	for (genvar i = 0; i < Q_W; i++) begin : g_srch
		if (i == 0) begin : g_first
			bmss_step #(.BIT(Q_W - 1)) u_step (.cur(pr_srch), .nxt(nxt[i]));
			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) begin
					vld_s[i] <= 1'b0;
				end else if (en) begin
					vld_s[i] <= pr_valid;
				end
			end
		end else begin : g_rest
			bmss_step #(.BIT(Q_W - 1 - i)) u_step (.cur(stp_s[i-1]), .nxt(nxt[i]));
			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) begin
					vld_s[i] <= 1'b0;
				end else if (en) begin
					vld_s[i] <= vld_s[i-1];
				end
			end
		end
		always_ff @(posedge clk) begin
			if (en) begin
				stp_s[i] <= nxt[i];
			end
		end
	end

	assign last = stp_s[Q_W-1];

	always_comb begin
		if (last.ovr) begin
			score_d = last.ovr_score;
		end else if (!last.mode) begin
			score_d = last.q;
		end else if (last.neg) begin
			score_d = SCORE_HALF - last.q;
		end else begin
			score_d = SCORE_HALF + last.q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (en) begin
			out_vld_q <= vld_s[Q_W-1];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			score_q <= score_d;
			cnt_q   <= last.cnt;
		end
	end

	assign out_valid  = out_vld_q;
	assign score      = score_q;
	assign count_u    = cnt_q.cnt_u;
	assign count_v    = cnt_q.cnt_v;
	assign count_both = cnt_q.cnt_b;

endmodule

### src/bmss_popcnt.sv
// Three-stage masked popcount of u, v and u AND v.
module bmss_popcnt (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      en,
	input  logic                      in_valid,
	input  logic [63:0]               mask_u,
	input  logic [63:0]               mask_v,
	input  logic [6:0]                n_eff,
	output logic                      out_valid,
	output bmss_pkg::bmss_cnt_t       cnt
);
	import bmss_pkg::*;

	localparam int CHUNKS = MASK_W / 8;

	logic [MASK_W-1:0] vmask;
	logic [MASK_W-1:0] u_s1, v_s1, b_s1;
	logic [3:0]        cu_s2 [CHUNKS];
	logic [3:0]        cv_s2 [CHUNKS];
	logic [3:0]        cb_s2 [CHUNKS];
	logic              vld_s1, vld_s2, vld_s3;
	bmss_cnt_t         cnt_s3;
	logic [CNT_W-1:0]  su, sv, sb;

	always_comb begin
		for (int t = 0; t < MASK_W; t++) begin
			vmask[t] = (7'(t) < n_eff);
		end
	end

	always_comb begin
		su = '0;
		sv = '0;
		sb = '0;
		for (int k = 0; k < CHUNKS; k++) begin
			su = su + CNT_W'(cu_s2[k]);
			sv = sv + CNT_W'(cv_s2[k]);
			sb = sb + CNT_W'(cb_s2[k]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
		end else if (en) begin
			vld_s1 <= in_valid;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			u_s1 <= mask_u & vmask;
			v_s1 <= mask_v & vmask;
			b_s1 <= mask_u & mask_v & vmask;
			for (int k = 0; k < CHUNKS; k++) begin
				cu_s2[k] <= 4'($countones(u_s1[8*k +: 8]));
				cv_s2[k] <= 4'($countones(v_s1[8*k +: 8]));
				cb_s2[k] <= 4'($countones(b_s1[8*k +: 8]));
			end
			cnt_s3.cnt_u <= su;
			cnt_s3.cnt_v <= sv;
			cnt_s3.cnt_b <= sb;
		end
	end

	assign out_valid = vld_s3;
	assign cnt       = cnt_s3;

endmodule

### src/bmss_prep.sv
// Two-stage setup of numerator, denominator and special cases for the search.
module bmss_prep (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   en,
	input  logic                   in_valid,
	input  bmss_pkg::bmss_cnt_t    cnt,
	input  logic [6:0]             n_eff,
	input  logic                   mode,
	output logic                   out_valid,
	output bmss_pkg::bmss_srch_t   srch
);
	import bmss_pkg::*;

	logic [13:0]       ncb, cucv, ncu, cuu, ncv, cvv, du14, dv14;
	logic signed [14:0] num;
	logic              degen;
	logic [CNT_W-1:0]  m;

	logic              vld_s4, vld_s5;
	logic [DU_W-1:0]   du_s4, dv_s4;
	logic signed [14:0] num_s4;
	logic              degen_s4, mode_s4;
	logic [CNT_W-1:0]  m_s4;
	bmss_cnt_t         cnt_s4;
	bmss_srch_t        srch_s5;

	logic [14:0]       anum15;
	logic [DU_W-1:0]   anum;
	logic [21:0]       den22, a2;
	bmss_srch_t        nxt;

	always_comb begin
		ncb  = 14'(n_eff) * 14'(cnt.cnt_b);
		cucv = 14'(cnt.cnt_u) * 14'(cnt.cnt_v);
		ncu  = 14'(n_eff) * 14'(cnt.cnt_u);
		cuu  = 14'(cnt.cnt_u) * 14'(cnt.cnt_u);
		ncv  = 14'(n_eff) * 14'(cnt.cnt_v);
		cvv  = 14'(cnt.cnt_v) * 14'(cnt.cnt_v);
		du14 = ncu - cuu;
		dv14 = ncv - cvv;
		num  = $signed({1'b0, ncb}) - $signed({1'b0, cucv});
		degen = (cnt.cnt_u == '0) || (cnt.cnt_u >= n_eff) ||
			(cnt.cnt_v == '0) || (cnt.cnt_v >= n_eff);
		m = (cnt.cnt_u > cnt.cnt_v) ? cnt.cnt_u : cnt.cnt_v;
	end

	always_comb begin
		anum15 = num_s4[14] ? 15'(-num_s4) : 15'(num_s4);
		anum   = anum15[DU_W-1:0];
		den22  = 22'(du_s4) * 22'(dv_s4);
		a2     = 22'(anum) * 22'(anum);
		nxt.mode = mode_s4;
		nxt.q    = '0;
		nxt.p    = '0;
		nxt.qd   = '0;
		nxt.neg  = num_s4[14];
		nxt.cnt  = cnt_s4;
		if (mode_s4) begin
			nxt.den       = den22[DEN_W-1:0];
			nxt.rhs       = {a2[20:0], 32'b0};
			nxt.ovr       = degen_s4;
			nxt.ovr_score = SCORE_HALF;
		end else begin
			nxt.den       = DEN_W'(m_s4);
			nxt.rhs       = RHS_W'(cnt_s4.cnt_b) << 17;
			nxt.ovr       = (m_s4 == '0);
			nxt.ovr_score = SCORE_ZERO;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
		end else if (en) begin
			vld_s4 <= in_valid;
			vld_s5 <= vld_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			du_s4    <= du14[DU_W-1:0];
			dv_s4    <= dv14[DU_W-1:0];
			num_s4   <= num;
			degen_s4 <= degen;
			mode_s4  <= mode;
			m_s4     <= m;
			cnt_s4   <= cnt;
			srch_s5  <= nxt;
		end
	end

	assign out_valid = vld_s5;
	assign srch      = srch_s5;

endmodule

### src/bmss_step.sv
// One bit of the rounding search: tries setting bit BIT of q.
module bmss_step #(
	parameter int BIT = 0
) (
	input  bmss_pkg::bmss_srch_t cur,
	output bmss_pkg::bmss_srch_t nxt
);
	import bmss_pkg::*;

	logic [QD_W-1:0]  qd_n;
	logic [P_W-1:0]   p_n;
	logic [LHS_W-1:0] lhs;

	always_comb begin
		qd_n = cur.qd + (QD_W'(cur.den) << BIT);
		p_n  = cur.p + (P_W'(cur.qd) << (BIT + 1)) + (P_W'(cur.den) << (2 * BIT));
		// mode 1: den*(2q-1)^2, mode 0: m*(2q-1)
		if (cur.mode) begin
			lhs = (LHS_W'(p_n) << 2) - (LHS_W'(qd_n) << 2) + LHS_W'(cur.den);
		end else begin
			lhs = (LHS_W'(qd_n) << 1) - LHS_W'(cur.den);
		end
		nxt = cur;
		if (lhs <= LHS_W'(cur.rhs)) begin
			nxt.q[BIT] = 1'b1;
			nxt.p      = p_n;
			nxt.qd     = qd_n;
		end
	end

endmodule

### verif/tb_binary_mask_similarity_score_core.sv
// Self-checking testbench for the binary mask similarity score core.
`timescale 1ns / 1ps

module tb_binary_mask_similarity_score_core;
	import bmss_pkg::*;

	typedef struct packed {
		logic [63:0] u;
		logic [63:0] v;
	} edge_req_t;

	typedef struct packed {
		logic [16:0] score;
		logic [6:0]  cu;
		logic [6:0]  cv;
		logic [6:0]  cb;
	} edge_score_t;

	localparam int LATENCY = 23;
	localparam int CYCLE_LIMIT = 400000;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic [63:0] mask_u = '0;
	logic [63:0] mask_v = '0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [16:0] score;
	logic [6:0]  count_u, count_v, count_both;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [1:0]  cfg_index = '0;
	logic [6:0]  cfg_data = '0;

	edge_req_t   pending_reqs[$];
	edge_score_t expected_scores[$];
	logic        mode_sh = 1'b1;
	logic [6:0]  tissues_sh = 7'd64;
	int          errors = 0;
	int          cycles = 0;
	int          n_sent = 0;
	int          n_recv = 0;
	int          in_gap = 0;
	int          out_gap = 0;
	logic        gaps_on = 1'b1;
	logic        in_taken = 1'b0;

	binary_mask_similarity_score_core DUT (.*);

	always #4 clk = ~clk;

	function automatic int rand_gap();
		if (!gaps_on) return 0;
		if ($urandom_range(0, 19) == 0) return $urandom_range(5, 30);
		if ($urandom_range(0, 2) == 0) return $urandom_range(1, 3);
		return 0;
	endfunction

	function automatic int popcount64(logic [63:0] x);
		int c;
		c = 0;
		for (int i = 0; i < 64; i++) c += x[i];
		return c;
	endfunction

	// largest q in 0..32768 with (2q-1)^2 * den <= (65536*|num|)^2
	function automatic edge_score_t score_edge(edge_req_t r);
		edge_score_t res;
		logic [63:0] keep, u, v;
		longint unsigned n, cu, cv, cb, m, anum, den, rhs, lo, hi, mid, t;
		longint num;
		n = (tissues_sh > 64) ? 64 : tissues_sh;
		keep = (n >= 64) ? '1 : ((64'd1 << n) - 1);
		u = r.u & keep;
		v = r.v & keep;
		cu = popcount64(u);
		cv = popcount64(v);
		cb = popcount64(u & v);
		if (mode_sh == 1'b0) begin
			m = (cu > cv) ? cu : cv;
			res.score = (m == 0) ? SCORE_ZERO : 17'((cb * 131072 + m) / (2 * m));
		end else if (cu == 0 || cu >= n || cv == 0 || cv >= n) begin
			res.score = SCORE_HALF;
		end else begin
			num = longint'(n * cb) - longint'(cu * cv);
			anum = (num < 0) ? -num : num;
			den = (n * cu - cu * cu) * (n * cv - cv * cv);
			rhs = (anum * 65536) * (anum * 65536);
			lo = 0;
			hi = 32768;
			while (lo < hi) begin
				mid = (lo + hi + 1) / 2;
				t = 2 * mid - 1;
				if (t * t * den <= rhs) lo = mid;
				else hi = mid - 1;
			end
			res.score = (num >= 0) ? 17'(32768 + lo) : 17'(32768 - lo);
		end
		res.cu = 7'(cu);
		res.cv = 7'(cv);
		res.cb = 7'(cb);
		return res;
	endfunction

	task automatic add_req(input edge_req_t r);
		pending_reqs = {pending_reqs, r};
	endtask

	// driver: request changes on the falling edge
	always @(negedge clk) begin
		if (arst_n) begin
			if (in_taken) begin
				in_gap = rand_gap();
			end
			if (!in_valid || in_taken) begin
				if (in_gap > 0) begin
					in_gap--;
					in_valid <= 1'b0;
				end else if (pending_reqs.size() > 0) begin
					edge_req_t r;
					r = pending_reqs.pop_front();
					in_valid <= 1'b1;
					mask_u <= r.u;
					mask_v <= r.v;
				end else begin
					in_valid <= 1'b0;
				end
			end
			if (out_gap > 0) begin
				out_gap--;
				out_stall <= 1'b1;
			end else begin
				out_stall <= 1'b0;
				out_gap = rand_gap();
			end
		end
	end

	// monitor: predicts each accepted request and checks results
	always @(posedge clk) begin
		cycles++;
		in_taken = arst_n && in_valid && !in_stall;
		if (in_taken) begin
			expected_scores = {expected_scores, score_edge('{u: mask_u, v: mask_v})};
			n_sent++;
		end
		if (arst_n && out_valid && !out_stall) begin
			edge_score_t exp_s;
			n_recv++;
			if (expected_scores.size() == 0) begin
				$display("%0t: unexpected result score=%0d", $time, score);
				errors++;
			end else begin
				exp_s = expected_scores.pop_front();
				if (score !== exp_s.score || count_u !== exp_s.cu ||
				    count_v !== exp_s.cv || count_both !== exp_s.cb) begin
					$display("%0t: expected score=%0d cu=%0d cv=%0d cb=%0d, got %0d %0d %0d %0d",
						$time, exp_s.score, exp_s.cu, exp_s.cv, exp_s.cb,
						score, count_u, count_v, count_both);
					errors++;
				end
			end
		end
		if (cycles > CYCLE_LIMIT) begin
			$display("%0t: timeout, %0d results still expected", $time, expected_scores.size());
			$display("end of test: mismatches");
			$finish;
		end
	end

	task automatic write_reg(input logic [1:0] idx, input logic [6:0] val);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		if (idx == REG_SCORE_MODE) mode_sh = val[0];
		else if (idx == REG_TISSUE_COUNT) tissues_sh = val;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic drain();
		while (pending_reqs.size() > 0 || in_valid || expected_scores.size() > 0)
			@(posedge clk);
		repeat (LATENCY + 4) @(posedge clk);
	endtask

	function automatic logic [63:0] rand64();
		return {$urandom, $urandom};
	endfunction

	// masks biased toward the valid range and correlated pairs
	function automatic edge_req_t rand_edge(int n);
		edge_req_t r;
		logic [63:0] keep;
		int k;
		k = $urandom_range(0, 9);
		r.u = rand64();
		if (k < 2) r.u = r.u & rand64();
		if (k == 2) r.u = r.u | rand64();
		case ($urandom_range(0, 4))
			0: r.v = r.u;
			1: r.v = r.u ^ (64'd1 << $urandom_range(0, 63));
			2: r.v = ~r.u;
			default: r.v = rand64();
		endcase
		if ($urandom_range(0, 3) == 0) begin
			keep = (n >= 64) ? '1 : ((64'd1 << n) - 1);
			r.u = r.u & keep;
			r.v = r.v & keep;
		end
		return r;
	endfunction

	initial begin
		int tcs[$];
		int phase_items;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// directed: reset settings, then extremes
		add_req('{u: '0, v: '0});
		add_req('{u: '1, v: '1});
		add_req('{u: '1, v: '0});
		add_req('{u: 64'h5555_5555_5555_5555, v: 64'hAAAA_AAAA_AAAA_AAAA});
		add_req('{u: 64'hFFFF_FFFF_0000_0000, v: 64'hFFFF_0000_FFFF_0000});
		add_req('{u: 64'h1, v: 64'h1});
		add_req('{u: 64'h8000_0000_0000_0000, v: 64'h1});
		add_req('{u: 64'h7FFF_FFFF_FFFF_FFFF, v: 64'hFFFF_FFFF_FFFF_FFFE});
		drain();
		write_reg(REG_SCORE_MODE, 7'd0);
		add_req('{u: '0, v: '0});
		add_req('{u: '1, v: '1});
		add_req('{u: 64'h3, v: 64'h1});
		add_req('{u: 64'hF0, v: 64'h0F});
		add_req('{u: 64'h7, v: 64'h1});
		drain();
		write_reg(REG_TISSUE_COUNT, 7'd0);
		add_req('{u: '1, v: '1});
		drain();
		write_reg(REG_SCORE_MODE, 7'd1);
		add_req('{u: '1, v: '1});
		drain();
		write_reg(REG_TISSUE_COUNT, 7'd127);
		add_req('{u: '1, v: 64'h1});
		add_req('{u: 64'h0F0F, v: 64'h00FF});
		drain();
		write_reg(2'd3, 7'd5); // unused index, must be ignored
		write_reg(2'd2, 7'd9);
		add_req('{u: 64'h3, v: 64'h6});
		drain();

		// random phases over mode and tissue count settings
		tcs = '{1, 2, 3, 64, 65, 127, 64, 37, 8, 63, 100, 17, 64, 2};
		foreach (tcs[i]) begin
			for (int md = 0; md < 2; md++) begin
				write_reg(REG_SCORE_MODE, 7'(md));
				write_reg(REG_TISSUE_COUNT, 7'(tcs[i]));
				gaps_on = (i % 4) != 3;
				phase_items = 28;
				for (int k = 0; k < phase_items; k++) add_req(rand_edge(tcs[i]));
				drain();
			end
		end
		gaps_on = 1'b1;

		$display("Covered %0d edges across both score modes and tissue counts 0..127,",
			n_sent);
		$display("with random gaps and output stalls; %0d results checked.", n_recv);
		if (errors == 0 && expected_scores.size() == 0) begin
			$display("end of test: clean");
		end else begin
			$display("end of test: mismatches");
		end
		$finish;
	end

endmodule

### sim.f
src/bmss_pkg.sv
src/bmss_popcnt.sv
src/bmss_prep.sv
src/bmss_step.sv
src/binary_mask_similarity_score_core.sv
verif/tb_binary_mask_similarity_score_core.sv
